// ----- rtl/core/ddc_pkg.sv -----
package ddc_pkg;

  localparam int unsigned MAX_YEAR_DEFAULT = 9999;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MINUTES_PER_DAY = 1440;
  localparam int unsigned SECONDS_PER_DAY = 86400;

  // Division of a year index below 2^14 by 100 as a multiply and shift.
  localparam int unsigned RECIP_100 = 5243;
  localparam int unsigned RECIP_100_SHIFT = 19;

  // Division of a magnitude below 2^23 by 7, 30 and 365.
  localparam int unsigned RECIP_7 = 9586981;
  localparam int unsigned RECIP_7_SHIFT = 26;
  localparam int unsigned RECIP_30 = 8947849;
  localparam int unsigned RECIP_30_SHIFT = 28;
  localparam int unsigned RECIP_365 = 5883517;
  localparam int unsigned RECIP_365_SHIFT = 31;

  localparam logic [1:0] REG_START_DAY = 2'd0;
  localparam logic [1:0] REG_START_MONTH = 2'd1;
  localparam logic [1:0] REG_START_YEAR = 2'd2;

  typedef struct packed {
    logic s1;
    logic s2;
  } ddc_stage_en_t;

  // Days in the whole months before a date in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] months);
    logic [8:0] days;
    case (months)
      4'd0: days = 9'd0;
      4'd1: days = 9'd31;
      4'd2: days = 9'd59;
      4'd3: days = 9'd90;
      4'd4: days = 9'd120;
      4'd5: days = 9'd151;
      4'd6: days = 9'd181;
      4'd7: days = 9'd212;
      4'd8: days = 9'd243;
      4'd9: days = 9'd273;
      4'd10: days = 9'd304;
      4'd11: days = 9'd334;
      default: days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

// ----- rtl/core/ddc_day_number.sv -----
module ddc_day_number #(
  parameter int unsigned MAX_YEAR = ddc_pkg::MAX_YEAR_DEFAULT
) (
  input  logic                  clk,
  input  ddc_pkg::ddc_stage_en_t en,
  input  logic [4:0]            day,
  input  logic [3:0]            month,
  input  logic [13:0]           year,
  output logic [22:0]           base,
  output logic [8:0]            mpart
);
  import ddc_pkg::*;

  logic [13:0] year_sat;
  logic [13:0] prior;
  logic [3:0]  month_m1;
  logic [3:0]  months;

  logic [13:0] year1;
  logic [13:0] prior1;
  logic [26:0] prior_q100;
  logic [24:0] prior_q400;
  logic [26:0] year_q100;
  logic [8:0]  cum1;
  logic        past_feb1;
  logic [4:0]  day1;

  logic [7:0]  year_div100;
  logic        div100;
  logic        leap;

  always_comb begin
    year_sat = (17'(year) > 17'(MAX_YEAR)) ? 14'(MAX_YEAR) : year;
    prior = (year_sat == 14'd0) ? 14'd0 : year_sat - 14'd1;
    month_m1 = (month == 4'd0) ? 4'd0 : month - 4'd1;
    months = (month_m1 > 4'd12) ? 4'd12 : month_m1;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      year1 <= year_sat;
      prior1 <= prior;
      prior_q100 <= 27'(prior) * 27'(RECIP_100);
      prior_q400 <= 25'(prior[13:2]) * 25'(RECIP_100);
      year_q100 <= 27'(year_sat) * 27'(RECIP_100);
      cum1 <= cum_days(months);
      past_feb1 <= (months >= 4'd2);
      day1 <= day;
    end
  end

  always_comb begin
    year_div100 = year_q100[RECIP_100_SHIFT +: 8];
    div100 = (15'(year1) == 15'(year_div100) * 15'(100));
    leap = ((year1[1:0] == 2'd0) && !div100) || (div100 && (year_div100[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      base <= 23'(prior1) * 23'(DAYS_PER_YEAR) + 23'(prior1[13:2])
            - 23'(prior_q100[RECIP_100_SHIFT +: 8]) + 23'(prior_q400[RECIP_100_SHIFT +: 6]);
      mpart <= cum1 + 9'(leap && past_feb1) + 9'(day1);
    end
  end

endmodule

// ----- rtl/core/date_difference_calculator.sv -----
// Gives the signed distance of a target date from the start date held in the
// configuration registers, as days, whole weeks, 30-day months and 365-day
// years (truncated toward zero) and as hours, minutes and seconds. Both dates
// count days from 1/1/1 under the Gregorian leap rule; years above MAX_YEAR
// saturate, and month and day are not checked. A date is taken every cycle while
// target_stall is low and passes through the six register stages of the
// datapath; a stalled result holds only the stages behind it that are full.
// Write the start date only while no beats are in flight.
module date_difference_calculator #(
  parameter int unsigned MAX_YEAR = ddc_pkg::MAX_YEAR_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [13:0]        cfg_data,
  input  logic               target_valid,
  output logic               target_stall,
  input  logic [4:0]         target_day,
  input  logic [3:0]         target_month,
  input  logic [13:0]        target_year,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [22:0] day_difference,
  output logic signed [19:0] week_difference,
  output logic signed [17:0] month_difference,
  output logic signed [14:0] year_difference,
  output logic signed [27:0] hour_difference,
  output logic signed [33:0] minute_difference,
  output logic signed [39:0] second_difference
);
  import ddc_pkg::*;

  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [13:0] start_year;

  logic [5:0] vld;
  logic [6:0] ld;

  ddc_stage_en_t dn_en;
  logic [22:0] target_base;
  logic [8:0]  target_mpart;
  logic [22:0] start_base;
  logic [8:0]  start_mpart;

  logic signed [23:0] diff;

  logic        neg4;
  logic [22:0] mag4;
  logic [22:0] day4;
  logic [27:0] hour4;
  logic [33:0] min4;
  logic [39:0] sec4;

  logic [46:0] prod7;
  logic [46:0] prod30;
  logic [46:0] prod365;

  logic        neg5;
  logic [19:0] q7;
  logic [17:0] q30;
  logic [14:0] q365;
  logic [22:0] day5;
  logic [27:0] hour5;
  logic [33:0] min5;
  logic [39:0] sec5;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_day <= '0;
      start_month <= '0;
      start_year <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_DAY: start_day <= cfg_data[4:0];
        REG_START_MONTH: start_month <= cfg_data[3:0];
        REG_START_YEAR: start_year <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ld[6] = !result_stall;
    for (int k = 5; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k + 1];
    end
  end

  assign target_stall = !ld[0];
  assign result_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= target_valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  assign dn_en.s1 = ld[0];
  assign dn_en.s2 = ld[1];

  ddc_day_number #(
    .MAX_YEAR(MAX_YEAR)
  ) u_target_dn (
    .clk  (clk),
    .en   (dn_en),
    .day  (target_day),
    .month(target_month),
    .year (target_year),
    .base (target_base),
    .mpart(target_mpart)
  );

  ddc_day_number #(
    .MAX_YEAR(MAX_YEAR)
  ) u_start_dn (
    .clk  (clk),
    .en   (dn_en),
    .day  (start_day),
    .month(start_month),
    .year (start_year),
    .base (start_base),
    .mpart(start_mpart)
  );

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      diff <= $signed(24'(target_base) + 24'(target_mpart) - 24'(start_base)
                      - 24'(start_mpart));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      neg4 <= diff[23];
      mag4 <= diff[23] ? 23'(-diff) : 23'(diff);
      day4 <= 23'(diff);
      hour4 <= 28'(diff) * 28'(HOURS_PER_DAY);
      min4 <= 34'(diff) * 34'(MINUTES_PER_DAY);
      sec4 <= 40'(diff) * 40'(SECONDS_PER_DAY);
    end
  end

  always_comb begin
    prod7 = 47'(mag4) * 47'(RECIP_7);
    prod30 = 47'(mag4) * 47'(RECIP_30);
    prod365 = 47'(mag4) * 47'(RECIP_365);
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      neg5 <= neg4;
      q7 <= prod7[RECIP_7_SHIFT +: 20];
      q30 <= prod30[RECIP_30_SHIFT +: 18];
      q365 <= prod365[RECIP_365_SHIFT +: 15];
      day5 <= day4;
      hour5 <= hour4;
      min5 <= min4;
      sec5 <= sec4;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      day_difference <= $signed(day5);
      week_difference <= $signed(neg5 ? -q7 : q7);
      month_difference <= $signed(neg5 ? -q30 : q30);
      year_difference <= $signed(neg5 ? -q365 : q365);
      hour_difference <= $signed(hour5);
      minute_difference <= $signed(min5);
      second_difference <= $signed(sec5);
    end
  end

  a_empty_takes_beat: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !target_stall)
    else $error("input stalled while the output register is empty");

  a_beats_conserved: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(vld) == $past($countones(vld))
              + $past(int'(target_valid && !target_stall))
              - $past(int'(result_valid && !result_stall))))
    else $error("pipeline lost or invented a beat");

  a_quotient_order: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> ((18'(q365) <= q30) && (20'(q30) <= q7)))
    else $error("quotients by 7, 30 and 365 out of order");

endmodule
